FILE: sv/lpd_pkg.sv
package lpd_pkg;

  localparam logic [2:0] ST_READING   = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_CSUM  = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam int unsigned PKT_LEN = 22;
  // Byte position of the last packet byte, as seen before the count advances.
  localparam logic [4:0] PKT_LAST_POS = 5'(PKT_LEN - 1);
  localparam logic [4:0] CSUM_LO_POS  = 5'(PKT_LEN - 2);
  localparam logic [4:0] DATA_FIRST   = 5'd4;
  localparam logic [4:0] COUNT_MAX    = 5'd31;

  localparam logic [7:0]  START_BYTE    = 8'hFA;
  localparam logic [7:0]  INDEX_LOW     = 8'hA0;
  localparam logic [7:0]  INDEX_HIGH    = 8'hF9;
  localparam logic [5:0]  RANGE_HI_MASK = 6'h3F;
  localparam logic [7:0]  SCAN_MAX      = 8'd255;

  // One decoded line, held while its results are delivered.
  typedef struct packed {
    logic [2:0]       status;
    logic [6:0]       idx;
    logic             wrapped;
    logic             complete;
    logic [15:0][7:0] readings;
  } rec_t;

endpackage

FILE: sv/lpd_if.sv
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_line;

  modport source (output valid, output rx_byte, output end_of_line, input ready);
  modport sink   (input valid, input rx_byte, input end_of_line, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [8:0]  angle_index;
  logic [13:0] range_value;
  logic [15:0] intensity_value;
  logic        scan_wrapped;
  logic        scan_complete;
  logic        last_result;

  modport source (output valid, output status, output angle_index, output range_value,
                  output intensity_value, output scan_wrapped, output scan_complete,
                  output last_result, input ready);
  modport sink   (input valid, input status, input angle_index, input range_value,
                  input intensity_value, input scan_wrapped, input scan_complete,
                  input last_result, output ready);
endinterface

interface lpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] min_packets;

  modport source (output valid, output min_packets, input ready);
  modport sink   (input valid, input min_packets, output ready);
endinterface

FILE: sv/lpd_line.sv
module lpd_line (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_line,
  input  logic [7:0]    min_packets,
  output lpd_pkg::rec_t rec_o
);
  import lpd_pkg::*;

  logic [4:0]       pos_r, pos_nxt;
  logic [25:0]      acc_r, acc_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [1:0][7:0]  hdr_r;
  logic [15:0][7:0] buf_r;
  logic [7:0]       rc_lo_r;
  logic [6:0]       prev_idx_r;
  logic             prev_valid_r;
  logic [7:0]       pkts_r, pkts_nxt;

  logic [15:0] word;
  logic [14:0] folded;
  logic [15:0] rx_csum;
  logic [2:0]  status;
  logic [6:0]  idx;
  logic        wrapped;

  always_comb begin
    word    = {rx_byte, hold_r};
    acc_nxt = acc_r;
    hold_nxt = hold_r;
    if (pos_r < CSUM_LO_POS) begin
      if (!pos_r[0]) begin
        hold_nxt = rx_byte;
      end else begin
        acc_nxt = {acc_r[24:0], 1'b0} + {10'b0, word};
      end
    end
    pos_nxt = (pos_r < COUNT_MAX) ? pos_r + 5'd1 : pos_r;
    // Every line, good or bad, leaves the line state clear.
    if (end_of_line) begin
      pos_nxt  = '0;
      acc_nxt  = '0;
      hold_nxt = '0;
    end
  end

  always_comb begin
    folded  = acc_r[14:0] + {4'b0, acc_r[25:15]};
    rx_csum = {rx_byte, rc_lo_r};
    idx     = 7'(hdr_r[1] - INDEX_LOW);
    priority if (pos_r != PKT_LAST_POS) begin
      status = ST_BAD_LEN;
    end else if (hdr_r[0] != START_BYTE) begin
      status = ST_BAD_START;
    end else if ({1'b0, folded} != rx_csum) begin
      status = ST_BAD_CSUM;
    end else if (hdr_r[1] < INDEX_LOW || hdr_r[1] > INDEX_HIGH) begin
      status = ST_BAD_INDEX;
    end else begin
      status = ST_READING;
    end
    wrapped = (status == ST_READING) && prev_valid_r && (idx < prev_idx_r);
    if (wrapped) begin
      pkts_nxt = 8'd1;
    end else if (pkts_r < SCAN_MAX) begin
      pkts_nxt = pkts_r + 8'd1;
    end else begin
      pkts_nxt = pkts_r;
    end

    rec_o.status   = status;
    rec_o.idx      = idx;
    rec_o.wrapped  = wrapped;
    rec_o.complete = wrapped && (pkts_r > min_packets);
    rec_o.readings = buf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      acc_r        <= '0;
      hold_r       <= '0;
      prev_idx_r   <= '0;
      prev_valid_r <= 1'b0;
      pkts_r       <= '0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      hold_r <= hold_nxt;
      if (end_of_line && status == ST_READING) begin
        prev_idx_r   <= idx;
        prev_valid_r <= 1'b1;
        pkts_r       <= pkts_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (pos_r < 5'd2) begin
        hdr_r[pos_r[0]] <= rx_byte;
      end
      if (pos_r == CSUM_LO_POS) begin
        rc_lo_r <= rx_byte;
      end
      for (int i = 0; i < 16; i++) begin
        if (pos_r == 5'(i) + DATA_FIRST) begin
          buf_r[i] <= rx_byte;
        end
      end
    end
  end

endmodule

FILE: sv/lidar_packet_decoder.sv
// Lidar packet decoder.
// in_bus carries one byte of a serial line per request; end_of_line marks the
// line's last byte. cfg_bus writes min_packets and is always ready; write it
// only while the decoder is idle.
// A good 22-byte packet gives four readings on out_bus, one per cycle when not
// stalled, the first carrying the scan flags. Any failed check gives a single
// error result. The first result of a line is valid in the cycle after its last
// byte is accepted. Bytes are taken one per cycle; bytes inside a line are always
// taken; a last byte waits only while the previous line still has results to
// deliver past the current cycle, since one record register holds the pending
// results. When the receiver stalls, the pending result holds its value and valid.
// Reset (rst_n low at a clock edge) drops any pending results, clears the line
// and scan state and sets min_packets to zero.
module lidar_packet_decoder (
  input  logic             clk,
  input  logic             rst_n,
  lpd_in_if.sink           in_bus,
  lpd_out_if.source        out_bus,
  lpd_cfg_if.sink          cfg_bus
);
  import lpd_pkg::*;

  logic [7:0] min_packets_r;
  rec_t       rec;
  rec_t       rec_r;
  logic       rec_valid_r;
  logic [1:0] slot_r;

  logic       in_fire;
  logic       out_fire;
  logic       out_last;
  logic       rec_free;
  logic       is_reading;
  logic [3:0] base;

  lpd_line u_line (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .rx_byte     (in_bus.rx_byte),
    .end_of_line (in_bus.end_of_line),
    .min_packets (min_packets_r),
    .rec_o       (rec)
  );

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_packets_r <= '0;
    end else if (cfg_bus.valid) begin
      min_packets_r <= cfg_bus.min_packets;
    end
  end

  assign is_reading = (rec_r.status == ST_READING);
  assign out_last   = !is_reading || (slot_r == 2'd3);
  assign out_fire   = out_bus.valid && out_bus.ready;
  assign rec_free   = !rec_valid_r || (out_fire && out_last);
  assign in_bus.ready = rec_free || !in_bus.end_of_line;
  assign in_fire    = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      slot_r      <= '0;
    end else if (in_fire && in_bus.end_of_line) begin
      rec_valid_r <= 1'b1;
      slot_r      <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        rec_valid_r <= 1'b0;
      end
      slot_r <= slot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_bus.end_of_line) begin
      rec_r <= rec;
    end
  end

  always_comb begin
    base = {slot_r, 2'b00};
    out_bus.valid         = rec_valid_r;
    out_bus.status        = rec_r.status;
    out_bus.last_result   = out_last;
    out_bus.angle_index   = is_reading ? {rec_r.idx, slot_r} : '0;
    out_bus.range_value   = is_reading ?
        {rec_r.readings[base | 4'd1][5:0] & RANGE_HI_MASK, rec_r.readings[base]} : '0;
    out_bus.intensity_value = is_reading ?
        {rec_r.readings[base | 4'd3], rec_r.readings[base | 4'd2]} : '0;
    out_bus.scan_wrapped  = is_reading && (slot_r == 2'd0) && rec_r.wrapped;
    out_bus.scan_complete = is_reading && (slot_r == 2'd0) && rec_r.complete;
  end

  // A new line's record may only land when the previous one is finished.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.end_of_line) |-> rec_free)
    else $error("record overwritten while results pending");

  // A non-final reading is followed by the next slot of the same record.
  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last) |=> (rec_valid_r && slot_r == $past(slot_r) + 2'd1))
    else $error("reading slot did not advance");

  // Error results are always single and start at slot zero.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_valid_r && !is_reading) |-> (slot_r == 2'd0 && out_bus.last_result))
    else $error("error result not a single result");

  // A complete scan is only reported together with a wrap.
  a_complete_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.scan_complete) |-> out_bus.scan_wrapped)
    else $error("scan complete without wrap");

endmodule
